[rtl/lspq_pkg.sv]
// shared types and codes for the linear scan priority queue
package lspq_pkg;

   localparam int DATA_W = 32;
   localparam int OP_W   = 2;
   localparam int ST_W   = 2;
   localparam int OCC_W  = 8;

   localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
   localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
   localparam logic [OP_W-1:0] OP_PEEK    = 2'd2;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;      // latch the incoming transaction, reset the scan
      logic scan_rd;      // read the entry at the pointer for comparison
      logic shift_start;  // point just past the selected entry
      logic shift_rd;     // read the entry at the pointer to move it down
      logic finish;       // update the count and load the result register
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic need_scan;    // dequeue or peek on a non-empty store
      logic is_dequeue;
      logic addr_last;    // pointer is at the last held entry
      logic shift_more;   // entries sit above the selected one
      logic rsp_free;     // result register can take a new result
   } sts_type;

endpackage

[rtl/lspq_ctrl.sv]
// controller state machine for the linear scan priority queue
module lspq_ctrl
   import lspq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] S_IDLE        = 3'd0;
   localparam logic [2:0] S_DISPATCH    = 3'd1;
   localparam logic [2:0] S_SCAN        = 3'd2;
   localparam logic [2:0] S_DRAIN       = 3'd3;
   localparam logic [2:0] S_SHIFT_SETUP = 3'd4;
   localparam logic [2:0] S_SHIFT       = 3'd5;
   localparam logic [2:0] S_SHIFT_DRAIN = 3'd6;
   localparam logic [2:0] S_DONE        = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_tready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = sts.need_scan ? S_SCAN : S_DONE;
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (sts.addr_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = sts.is_dequeue ? S_SHIFT_SETUP : S_DONE;
         end
         S_SHIFT_SETUP: begin
            cmd.shift_start = 1'b1;
            state_in        = sts.shift_more ? S_SHIFT : S_DONE;
         end
         S_SHIFT: begin
            cmd.shift_rd = 1'b1;
            if (sts.addr_last) begin
               state_in = S_SHIFT_DRAIN;
            end
         end
         S_SHIFT_DRAIN: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/lspq_dpath.sv]
// datapath of the linear scan priority queue: entry memory, scan and shift
module lspq_dpath
   import lspq_pkg::*;
#(
   parameter int CAPACITY = 128
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output sts_type                  sts,
   input  logic [OP_W-1:0]          req_op,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic signed [DATA_W-1:0] req_priority,
   input  logic                     rsp_tready,
   output logic                     rsp_tvalid,
   output logic [ST_W-1:0]          rsp_status,
   output logic signed [DATA_W-1:0] rsp_top_value,
   output logic signed [DATA_W-1:0] rsp_top_priority,
   output logic [OCC_W-1:0]         rsp_occupancy
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   // entry memory, priority in the upper half
   logic [2*DATA_W-1:0] mem [CAPACITY];
   logic [2*DATA_W-1:0] rd_data_ff;

   logic [OP_W-1:0]          op_ff;
   logic signed [DATA_W-1:0] val_ff;
   logic signed [DATA_W-1:0] pri_ff;
   logic [CW-1:0]            count_ff, count_in;
   logic [AW-1:0]            addr_ff, addr_in;
   logic [AW-1:0]            rd_idx_ff;
   logic                     scan_pend_ff, shift_pend_ff;
   logic                     first_ff;
   logic [AW-1:0]            best_idx_ff;
   logic signed [DATA_W-1:0] best_val_ff, best_pri_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ST_W-1:0]          status_ff, status_in;
   logic signed [DATA_W-1:0] top_val_ff, top_val_in;
   logic signed [DATA_W-1:0] top_pri_ff, top_pri_in;
   logic [OCC_W-1:0]         occ_ff;

   logic                     empty, full, is_select, enq_ok, deq_ok, better, take;
   logic                     mem_we, mem_re;
   logic [AW-1:0]            mem_wa;
   logic [2*DATA_W-1:0]      mem_wd;
   logic signed [DATA_W-1:0] rd_val, rd_pri;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CW'(CAPACITY));
   assign is_select = (op_ff == OP_DEQUEUE) || (op_ff == OP_PEEK);
   assign enq_ok    = cmd.finish && (op_ff == OP_ENQUEUE) && !full;
   assign deq_ok    = cmd.finish && (op_ff == OP_DEQUEUE) && !empty;

   assign rd_val = rd_data_ff[DATA_W-1:0];
   assign rd_pri = rd_data_ff[2*DATA_W-1:DATA_W];

   // strictly better keeps the earliest of equal entries
   assign better = (rd_pri > best_pri_ff) ||
                   ((rd_pri == best_pri_ff) && (rd_val > best_val_ff));
   assign take   = scan_pend_ff && (first_ff || better);

   assign sts.need_scan  = is_select && !empty;
   assign sts.is_dequeue = (op_ff == OP_DEQUEUE);
   assign sts.addr_last  = ((CW'(addr_ff) + CW'(1)) == count_ff);
   assign sts.shift_more = ((CW'(best_idx_ff) + CW'(1)) < count_ff);
   assign sts.rsp_free   = !rsp_valid_ff || rsp_tready;

   assign mem_re = cmd.scan_rd || cmd.shift_rd;
   assign mem_we = shift_pend_ff || enq_ok;
   assign mem_wa = shift_pend_ff ? (rd_idx_ff - AW'(1)) : AW'(count_ff);
   assign mem_wd = shift_pend_ff ? rd_data_ff : {pri_ff, val_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[addr_ff];
      end
   end

   always_comb begin
      addr_in = addr_ff;
      if (cmd.capture) begin
         addr_in = '0;
      end else if (cmd.shift_start) begin
         addr_in = best_idx_ff + AW'(1);
      end else if (mem_re) begin
         addr_in = addr_ff + AW'(1);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (enq_ok) begin
         count_in = count_ff + CW'(1);
      end else if (deq_ok) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      status_in  = ST_OK;
      top_val_in = '0;
      top_pri_in = '0;
      if (op_ff == OP_ENQUEUE) begin
         if (full) begin
            status_in = ST_FULL;
         end
      end else if (is_select) begin
         if (empty) begin
            status_in = ST_EMPTY;
         end else begin
            top_val_in = best_val_ff;
            top_pri_in = best_pri_ff;
         end
      end
   end

   assign rsp_valid_in = cmd.finish || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         scan_pend_ff  <= 1'b0;
         shift_pend_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         scan_pend_ff  <= cmd.scan_rd;
         shift_pend_ff <= cmd.shift_rd;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      if (mem_re) begin
         rd_idx_ff <= addr_ff;
      end
      if (cmd.capture) begin
         op_ff    <= req_op;
         val_ff   <= req_value;
         pri_ff   <= req_priority;
         first_ff <= 1'b1;
      end else if (scan_pend_ff) begin
         first_ff <= 1'b0;
      end
      if (take) begin
         best_idx_ff <= rd_idx_ff;
         best_val_ff <= rd_val;
         best_pri_ff <= rd_pri;
      end
      if (cmd.finish) begin
         status_ff  <= status_in;
         top_val_ff <= top_val_in;
         top_pri_ff <= top_pri_in;
         occ_ff     <= OCC_W'(count_in);
      end
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_top_value    = top_val_ff;
   assign rsp_top_priority = top_pri_ff;
   assign rsp_occupancy    = occ_ff;

endmodule

[rtl/linear_scan_priority_queue_core.sv]
// linear scan priority queue: unsorted entry store with scan select and shift remove
// sequence: enqueue and unused op pass dispatch and done; peek scans the n held entries, dequeue also
//   shifts those above the selected one down; one memory read port is walked one entry per cycle
// throughput: one transaction in flight; the next is taken while the result waits
// reset: synchronous active high, empties the queue; entry memory itself is not cleared
module linear_scan_priority_queue_core
   import lspq_pkg::*;
#(
   parameter int CAPACITY = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // item_value [31:0], item_priority [63:32]
   input  logic [1:0]  req_tuser,  // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // top_value [31:0], top_priority [63:32], occupancy [71:64]
   output logic [1:0]  rsp_tuser   // status
);

   cmd_type cmd;
   sts_type sts;

   logic signed [DATA_W-1:0] top_value;
   logic signed [DATA_W-1:0] top_priority;
   logic [OCC_W-1:0]         occupancy;
   logic [ST_W-1:0]          status;

   // sequencer: dispatch, scan, shift down, publish
   lspq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // memory, best-entry registers, count and result register
   lspq_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_op           (req_tuser),
      .req_value        (req_tdata[31:0]),
      .req_priority     (req_tdata[63:32]),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_status       (status),
      .rsp_top_value    (top_value),
      .rsp_top_priority (top_priority),
      .rsp_occupancy    (occupancy)
   );

   // result packing, lowest field first
   assign rsp_tdata = {occupancy, top_priority, top_value};
   assign rsp_tuser = status;

`ifndef SYNTHESIS
   // an accepted transaction keeps the input closed until its result is built
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken again right after an accepted transaction");

   // an empty answer carries no selected entry and reports zero occupancy
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == ST_EMPTY)) |->
         ((rsp_tdata[63:0] == 64'd0) && (rsp_tdata[71:64] == 8'd0)))
      else $error("empty status with nonzero result fields");

   // a dropped insert only happens with the store at capacity
   a_full_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == ST_FULL)) |-> (rsp_tdata[71:64] == 8'(CAPACITY)))
      else $error("full status while occupancy is below capacity");

   // a new result is only loaded when the result register has room
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten before it was taken");
`endif

endmodule

[tb/sv/testbench.sv]
// stream-level test of the linear scan priority queue core with a queue-based predictor
module testbench
   import lspq_pkg::*;
();

   localparam int CAPACITY        = 128;
   localparam int WATCHDOG_LIMIT  = 5000;  // far beyond a full dequeue plus the long hold
   localparam int DRAIN_CYCLES    = 300;   // covers a dequeue over a full store
   localparam int RANDOM_OPS      = 420;
   localparam int LONG_HOLD       = 400;

   // op code the block must ignore
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};

   // one held pair, in arrival order inside the predictor
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] prio;
   } queue_entry_type;

   // fields of one result transaction
   typedef struct packed {
      logic [ST_W-1:0]          status;
      logic signed [DATA_W-1:0] top_value;
      logic signed [DATA_W-1:0] top_prio;
      logic [OCC_W-1:0]         occupancy;
   } queue_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;  // item_value [31:0], item_priority [63:32]
   logic [1:0]  req_tuser = '0;  // op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;       // top_value [31:0], top_priority [63:32], occupancy [71:64]
   logic [1:0]  rsp_tuser;       // status

   queue_entry_type  held_entries[$];     // predictor copy of the store
   queue_result_type pending_results[$];  // predicted results, oldest first
   queue_result_type oldest_result;

   int error_count     = 0;
   int idle_cycles     = 0;
   int rsp_hold_cycles = 0;   // long receiver hold, picked up by the receiver process
   bit sender_quiet    = 1'b0;
   bit receiver_quiet  = 1'b0;

   linear_scan_priority_queue_core #(
      .CAPACITY (CAPACITY)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // predictor: unsorted store, scan for highest priority, ties to larger value,
   // then to the earliest entry; dequeue removes and closes the gap
   // ---------------------------------------------------------------------------
   function automatic queue_result_type apply_queue_op(logic [OP_W-1:0] op,
                                                       logic signed [DATA_W-1:0] value,
                                                       logic signed [DATA_W-1:0] prio);
      queue_result_type result;
      int best;
      result = '{status: ST_OK, top_value: '0, top_prio: '0, occupancy: '0};
      if (op == OP_ENQUEUE) begin
         if (held_entries.size() >= CAPACITY) begin
            result.status = ST_FULL;     // pair dropped
         end else begin
            held_entries.push_back('{value: value, prio: prio});
         end
      end else if (op == OP_DEQUEUE || op == OP_PEEK) begin
         if (held_entries.size() == 0) begin
            result.status = ST_EMPTY;
         end else begin
            best = 0;
            // strict compares keep the earliest entry on a full tie
            for (int i = 1; i < held_entries.size(); i++) begin
               if (held_entries[i].prio > held_entries[best].prio ||
                   (held_entries[i].prio == held_entries[best].prio &&
                    held_entries[i].value > held_entries[best].value)) begin
                  best = i;
               end
            end
            result.top_value = held_entries[best].value;
            result.top_prio  = held_entries[best].prio;
            if (op == OP_DEQUEUE) begin
               held_entries.delete(best);
            end
         end
      end
      // the unused op code falls through: ok status, store untouched
      result.occupancy = OCC_W'(held_entries.size());
      return result;
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------

   // idle cycles before a transaction; at least a quarter of them go back to back, all when quiet
   function automatic int draw_gap(bit quiet);
      if (quiet || $urandom_range(0, 3) == 0) begin
         return 0;
      end
      return $urandom_range(0, 14);
   endfunction

   // extremes, a narrow band to force ties, or any 32-bit pattern
   function automatic logic signed [DATA_W-1:0] draw_word(bit narrow);
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         return WORD_MIN;
      end
      if (pick == 1) begin
         return WORD_MAX;
      end
      if (pick < 4 || (narrow && pick < 8)) begin
         return DATA_W'($urandom_range(0, 6)) - 3;
      end
      return $urandom();
   endfunction

   function automatic logic [OP_W-1:0] draw_op(bit grow);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         return OP_UNUSED;
      end
      if (pick < (grow ? 60 : 35)) begin
         return OP_ENQUEUE;
      end
      if (pick < 80) begin
         return OP_DEQUEUE;
      end
      return OP_PEEK;
   endfunction

   // offer one transaction and wait for it to be taken; the expectation is
   // queued at the accepting edge, well before its result can appear
   task automatic issue_op(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value,
                           logic signed [DATA_W-1:0] prio);
      int gap;
      gap = draw_gap(sender_quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {prio, value};
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(apply_queue_op(op, value, prio));
   endtask

   // ---------------------------------------------------------------------------
   // receiver: random stalls per result, plus an occasional long hold
   // ---------------------------------------------------------------------------
   initial begin
      int stall;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         stall = draw_gap(receiver_quiet);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // ---------------------------------------------------------------------------
   // checker: every accepted result against the oldest expectation
   // ---------------------------------------------------------------------------
   task automatic check_field(string field_name, longint expected_val, longint actual_val);
      if (expected_val != actual_val) begin
         $error("%s mismatch: expected %0d, actual %0d", field_name, expected_val,
                actual_val);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result transaction with no expectation waiting");
            error_count++;
         end else begin
            oldest_result = pending_results.pop_front();
            check_field("status", oldest_result.status, rsp_tuser);
            check_field("top_value", oldest_result.top_value, $signed(rsp_tdata[31:0]));
            check_field("top_priority", oldest_result.top_prio, $signed(rsp_tdata[63:32]));
            check_field("occupancy", oldest_result.occupancy, rsp_tdata[71:64]);
         end
      end
   end

   // watchdog: ends the run when neither side moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // empty store, ignored op, extreme fields and every tie-break rule
   task automatic test_directed();
      issue_op(OP_PEEK, 0, 0);                  // peek on empty
      issue_op(OP_DEQUEUE, WORD_MAX, WORD_MIN); // dequeue on empty
      issue_op(OP_UNUSED, 0, 0);                // ignored on empty
      issue_op(OP_ENQUEUE, WORD_MAX, WORD_MIN); // most negative priority
      issue_op(OP_PEEK, 0, 0);                  // still selectable when alone
      issue_op(OP_ENQUEUE, WORD_MIN, WORD_MIN); // priority tie, smaller value
      issue_op(OP_ENQUEUE, 0, WORD_MAX);
      issue_op(OP_ENQUEUE, -1, WORD_MAX);       // priority tie, value 0 must win
      issue_op(OP_ENQUEUE, 0, WORD_MAX);        // full tie, earliest wins
      issue_op(OP_UNUSED, WORD_MAX, WORD_MAX);  // ignored with data set
      issue_op(OP_PEEK, 0, 0);
      repeat (6) issue_op(OP_DEQUEUE, 0, 0);    // drain in order, last one empty
      issue_op(OP_ENQUEUE, WORD_MIN, WORD_MAX);
      issue_op(OP_PEEK, WORD_MIN, WORD_MIN);
      issue_op(OP_DEQUEUE, -1, -1);
   endtask

   // fill to capacity, overflow with full status, then remove from a full store
   task automatic test_fill_to_capacity();
      sender_quiet = 1'b1;
      for (int i = 0; i < CAPACITY + 4; i++) begin
         if (i == CAPACITY / 2) begin
            sender_quiet = 1'b0;
         end
         issue_op(OP_ENQUEUE, draw_word(1'b0), draw_word(1'b1));
      end
      issue_op(OP_PEEK, draw_word(1'b0), draw_word(1'b0));
      repeat (8) issue_op(OP_DEQUEUE, draw_word(1'b0), draw_word(1'b0));
   endtask

   // random mix whose bias swings between growing and shrinking the store
   task automatic test_random_ops();
      bit grow;
      for (int i = 0; i < RANDOM_OPS; i++) begin
         grow           = ((i / 70) % 2) == 1;
         receiver_quiet = (i >= 210 && i < 280);
         sender_quiet   = (i >= 280 && i < 350);
         issue_op(draw_op(grow), draw_word(1'b0), draw_word(1'b1));
      end
      receiver_quiet = 1'b0;
      sender_quiet   = 1'b0;
   endtask

   // receiver holds off while the sender keeps offering, so input stalls
   task automatic test_output_backpressure();
      sender_quiet    = 1'b1;
      rsp_hold_cycles = LONG_HOLD;
      for (int i = 0; i < 24; i++) begin
         issue_op((i % 3 == 2) ? OP_PEEK : OP_ENQUEUE, draw_word(1'b0), draw_word(1'b1));
      end
      sender_quiet = 1'b0;
   endtask

   // empty the store, then hit the empty case once more
   task automatic test_drain();
      while (held_entries.size() > 0) begin
         issue_op(OP_DEQUEUE, draw_word(1'b0), draw_word(1'b0));
      end
      issue_op(OP_DEQUEUE, 0, 0);
      issue_op(OP_PEEK, 0, 0);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_fill_to_capacity();
      test_random_ops();
      test_output_backpressure();
      test_drain();
      req_tvalid <= 1'b0;
      // results still in flight, then a quiet stretch for strays
      wait (pending_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
